>>> rtl/core/scpf_pkg.sv
// scpf_pkg: types, codes and constants shared by the servo command packet framer
// used by the front, queue, back, top level and checker; depends on nothing
`default_nettype none

package scpf_pkg;

    // command modes as carried in the mode field
    typedef enum logic [2:0] {
        MODE_PING       = 3'd0,
        MODE_LIMIT      = 3'd1,
        MODE_POSITION   = 3'd2,
        MODE_REGISTERED = 3'd3,
        MODE_ACTION     = 3'd4,
        MODE_SYNC       = 3'd5
    } scpf_mode_t;

    // packet framing constants
    localparam logic [7:0] HEADER_BYTE   = 8'hFF;
    localparam logic [7:0] BROADCAST_ID  = 8'hFE;
    localparam logic [15:0] CLAMP_MAX    = 16'd1023;

    // length field values
    localparam logic [7:0] LEN_SHORT     = 8'h02;
    localparam logic [7:0] LEN_WRITE     = 8'h07;
    localparam logic [7:0] LEN_SYNC      = 8'h0E;

    // instruction codes
    localparam logic [7:0] INSTR_PING      = 8'h01;
    localparam logic [7:0] INSTR_WRITE     = 8'h03;
    localparam logic [7:0] INSTR_REG_WRITE = 8'h04;
    localparam logic [7:0] INSTR_ACTION    = 8'h05;
    localparam logic [7:0] INSTR_SYNC      = 8'h83;

    // control table addresses and sync data length
    localparam logic [7:0] ADDR_CW_LIMIT = 8'h06;
    localparam logic [7:0] ADDR_GOAL_POS = 8'h1E;
    localparam logic [7:0] SYNC_DATA_LEN = 8'h04;

    // packet geometry: bytes between the header and the checksum
    localparam int unsigned BODY_LEN  = 15;
    localparam int unsigned BODY_IDXW = 4;
    localparam int unsigned IDX_W     = 5;

    // index of the checksum byte for each packet size
    localparam logic [IDX_W-1:0] LAST_IDX_SHORT = 5'd5;
    localparam logic [IDX_W-1:0] LAST_IDX_WRITE = 5'd10;
    localparam logic [IDX_W-1:0] LAST_IDX_SYNC  = 5'd17;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // one command as it arrives
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  servo_id;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [7:0]  servo_id_two;
        logic [15:0] word_c;
        logic [15:0] word_d;
    } scpf_cmd_t;

    // one byte of packet as it leaves
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } scpf_out_t;

    // a classified packet waiting to be sent
    typedef struct packed {
        logic [BODY_LEN-1:0][7:0] body;
        logic [IDX_W-1:0]         last_idx;
    } scpf_desc_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } scpf_qstat_t;

endpackage

`default_nettype wire

>>> rtl/core/scpf_front.sv
// scpf_front: accepts commands and classifies them into packet descriptors
// depends on scpf_pkg
`default_nettype none

module scpf_front (
    input  wire  scpf_pkg::scpf_cmd_t   cmd,
    input  wire  logic                  cmd_valid,
    output logic                        cmd_stall,
    input  wire  scpf_pkg::scpf_qstat_t qstat,
    output logic                        push,
    output scpf_pkg::scpf_desc_t        desc
);

    // saturate a word to the servo range
    function automatic logic [15:0] clamp_word(input logic [15:0] w);
        return (w > scpf_pkg::CLAMP_MAX) ? scpf_pkg::CLAMP_MAX : w;
    endfunction

    logic        mode_ok;
    logic [15:0] a_clamped;
    logic [15:0] b_clamped;

    // hold the sender off while the queue is full
    assign cmd_stall = qstat.full;

    assign a_clamped = clamp_word(cmd.word_a);
    assign b_clamped = clamp_word(cmd.word_b);

    // build the bytes between header and checksum
    always_comb
    begin
        desc    = '0;
        mode_ok = 1'b1;
        unique case (cmd.mode)
            scpf_pkg::MODE_PING:
            begin
                desc.body[0]  = cmd.servo_id;
                desc.body[1]  = scpf_pkg::LEN_SHORT;
                desc.body[2]  = scpf_pkg::INSTR_PING;
                desc.last_idx = scpf_pkg::LAST_IDX_SHORT;
            end
            scpf_pkg::MODE_LIMIT, scpf_pkg::MODE_POSITION:
            begin
                desc.body[0]  = cmd.servo_id;
                desc.body[1]  = scpf_pkg::LEN_WRITE;
                desc.body[2]  = scpf_pkg::INSTR_WRITE;
                desc.body[3]  = (cmd.mode == scpf_pkg::MODE_LIMIT) ?
                                scpf_pkg::ADDR_CW_LIMIT : scpf_pkg::ADDR_GOAL_POS;
                desc.body[4]  = a_clamped[7:0];
                desc.body[5]  = a_clamped[15:8];
                desc.body[6]  = b_clamped[7:0];
                desc.body[7]  = b_clamped[15:8];
                desc.last_idx = scpf_pkg::LAST_IDX_WRITE;
            end
            scpf_pkg::MODE_REGISTERED:
            begin
                desc.body[0]  = cmd.servo_id;
                desc.body[1]  = scpf_pkg::LEN_WRITE;
                desc.body[2]  = scpf_pkg::INSTR_REG_WRITE;
                desc.body[3]  = scpf_pkg::ADDR_GOAL_POS;
                desc.body[4]  = cmd.word_a[7:0];
                desc.body[5]  = cmd.word_a[15:8];
                desc.body[6]  = cmd.word_b[7:0];
                desc.body[7]  = cmd.word_b[15:8];
                desc.last_idx = scpf_pkg::LAST_IDX_WRITE;
            end
            scpf_pkg::MODE_ACTION:
            begin
                desc.body[0]  = scpf_pkg::BROADCAST_ID;
                desc.body[1]  = scpf_pkg::LEN_SHORT;
                desc.body[2]  = scpf_pkg::INSTR_ACTION;
                desc.last_idx = scpf_pkg::LAST_IDX_SHORT;
            end
            scpf_pkg::MODE_SYNC:
            begin
                desc.body[0]  = scpf_pkg::BROADCAST_ID;
                desc.body[1]  = scpf_pkg::LEN_SYNC;
                desc.body[2]  = scpf_pkg::INSTR_SYNC;
                desc.body[3]  = scpf_pkg::ADDR_GOAL_POS;
                desc.body[4]  = scpf_pkg::SYNC_DATA_LEN;
                desc.body[5]  = cmd.servo_id;
                desc.body[6]  = cmd.word_a[7:0];
                desc.body[7]  = cmd.word_a[15:8];
                desc.body[8]  = cmd.word_b[7:0];
                desc.body[9]  = cmd.word_b[15:8];
                desc.body[10] = cmd.servo_id_two;
                desc.body[11] = cmd.word_c[7:0];
                desc.body[12] = cmd.word_c[15:8];
                desc.body[13] = cmd.word_d[7:0];
                desc.body[14] = cmd.word_d[15:8];
                desc.last_idx = scpf_pkg::LAST_IDX_SYNC;
            end
            default:
            begin
                // undefined modes are taken and dropped
                mode_ok = 1'b0;
            end
        endcase
    end

    assign push = cmd_valid && !qstat.full && mode_ok;

endmodule

`default_nettype wire

>>> rtl/core/scpf_queue.sv
// scpf_queue: small register queue of packet descriptors between front and back
// depends on scpf_pkg
`default_nettype none

module scpf_queue #(
    parameter int unsigned Depth = scpf_pkg::QUEUE_DEPTH
) (
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  logic                  push,
    input  wire  scpf_pkg::scpf_desc_t  push_desc,
    input  wire  logic                  pop,
    output scpf_pkg::scpf_desc_t        head_desc,
    output scpf_pkg::scpf_qstat_t       qstat
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    scpf_pkg::scpf_desc_t entries_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    // status and head entry
    assign qstat.full  = (count_reg == CntFull);
    assign qstat.empty = (count_reg == '0);
    assign head_desc   = entries_reg[rd_ptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // descriptor storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/scpf_back.sv
// scpf_back: serializes queued packet descriptors into bytes with a running checksum
// depends on scpf_pkg
`default_nettype none

module scpf_back (
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  scpf_pkg::scpf_desc_t  desc,
    input  wire  scpf_pkg::scpf_qstat_t qstat,
    output logic                        pop,
    output logic                        pkt_valid,
    input  wire  logic                  pkt_stall,
    output scpf_pkg::scpf_out_t         pkt
);

    localparam int unsigned IdxW = scpf_pkg::IDX_W;
    localparam int unsigned BodyIdxW = scpf_pkg::BODY_IDXW;

    logic [IdxW-1:0]     idx_reg, idx_next;
    logic [7:0]          sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    scpf_pkg::scpf_out_t out_reg, out_next;
    logic                advance;
    logic                emit;
    logic                in_header;
    logic                is_last;
    logic [IdxW-1:0]     body_off;
    logic [7:0]          cur_byte;

    assign pkt_valid = out_valid_reg;
    assign pkt       = out_reg;

    // output register frees up when empty or taken
    assign advance = !out_valid_reg || !pkt_stall;
    assign emit    = advance && !qstat.empty;

    // pick the byte at the current position
    assign in_header = (idx_reg < IdxW'(2));
    assign is_last   = (idx_reg == desc.last_idx);
    assign body_off  = idx_reg - IdxW'(2);

    always_comb
    begin
        if (in_header)
        begin
            cur_byte = scpf_pkg::HEADER_BYTE;
        end
        else if (is_last)
        begin
            cur_byte = ~sum_reg;
        end
        else
        begin
            cur_byte = desc.body[body_off[BodyIdxW-1:0]];
        end
    end

    // sequencing of positions and checksum
    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.packet_byte = cur_byte;
            out_next.last_byte   = is_last;
            if (is_last)
            begin
                idx_next = '0;
                sum_next = '0;
                pop      = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                if (!in_header)
                begin
                    sum_next = sum_reg + cur_byte;
                end
            end
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/servo_command_packet_framer.sv
// servo_command_packet_framer: top level of the servo instruction packet framer
// depends on scpf_pkg, scpf_front, scpf_queue and scpf_back
//
// usage
//   cmd channel: one servo command per request (mode, ids, four 16-bit words),
//   taken when cmd_valid is high and cmd_stall low. cmd_stall rises only while
//   the descriptor queue (QueueDepth commands) is full.
//   pkt channel: one packet byte per request, last_byte marks the checksum.
//   a ping or action packet is 6 bytes, a limit, position or registered write
//   11 bytes, a sync pair write 18 bytes. modes 6 and 7 are taken and dropped.
// flow and throughput
//   a taken command is registered in the queue, and its first header byte is then
//   registered in the output register once the back end is free. the back end
//   sends one byte per cycle while pkt_stall is low; the byte serializer and its output register set this.
//   commands keep flowing into the queue while a packet is being sent, until it fills.
// reset and stalls
//   rst_n clears the queue, the byte position and the output valid; no
//   clearing pass is needed. while pkt_stall is high the output byte holds
//   and the back end waits; the front keeps taking commands until the
//   queue fills.
`default_nettype none

module servo_command_packet_framer #(
    parameter int unsigned QueueDepth = scpf_pkg::QUEUE_DEPTH
) (
    input  wire  logic                clk,
    input  wire  logic                rst_n,
    input  wire  scpf_pkg::scpf_cmd_t cmd,
    input  wire  logic                cmd_valid,
    output logic                      cmd_stall,
    output scpf_pkg::scpf_out_t       pkt,
    output logic                      pkt_valid,
    input  wire  logic                pkt_stall
);

    scpf_pkg::scpf_desc_t  push_desc;
    scpf_pkg::scpf_desc_t  head_desc;
    scpf_pkg::scpf_qstat_t qstat;
    logic                  push;
    logic                  pop;

    // decode and classify
    scpf_front u_front (
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .qstat     (qstat),
        .push      (push),
        .desc      (push_desc)
    );

    // decoupling queue
    scpf_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .qstat     (qstat)
    );

    // byte serializer
    scpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc      (head_desc),
        .qstat     (qstat),
        .pop       (pop),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt)
    );

endmodule

`default_nettype wire

>>> rtl/core/scpf_checker.sv
// scpf_checker: port-level assertions for the servo command packet framer
// depends on scpf_pkg; bound to servo_command_packet_framer
`default_nettype none

module scpf_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire scpf_pkg::scpf_out_t pkt,
    input wire logic                pkt_valid,
    input wire logic                pkt_stall
);

    localparam int unsigned IdxW = scpf_pkg::IDX_W;

    logic [IdxW-1:0] pos_reg, pos_next;
    logic            out_take;

    assign out_take = pkt_valid && !pkt_stall;

    // position of the next byte within its packet
    always_comb
    begin
        pos_next = pos_reg;
        if (out_take)
        begin
            pos_next = pkt.last_byte ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // a stalled byte stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_stall |=> pkt_valid)
        else $error("packet byte withdrawn while stalled");

    // a stalled byte does not change
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_stall |=> $stable(pkt))
        else $error("packet byte changed while stalled");

    // every packet opens with two header bytes
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && (pos_reg < IdxW'(2)) |->
            (pkt.packet_byte == scpf_pkg::HEADER_BYTE) && !pkt.last_byte)
        else $error("packet header byte wrong");

    // the checksum closes a packet of a legal size
    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && pkt.last_byte |->
            (pos_reg == scpf_pkg::LAST_IDX_SHORT) ||
            (pos_reg == scpf_pkg::LAST_IDX_WRITE) ||
            (pos_reg == scpf_pkg::LAST_IDX_SYNC))
        else $error("packet ended at an illegal length");

    // no packet runs past the longest size
    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && (pos_reg == scpf_pkg::LAST_IDX_SYNC) |-> pkt.last_byte)
        else $error("packet longer than the longest size");

endmodule

bind servo_command_packet_framer scpf_checker u_scpf_checker (.*);

`default_nettype wire

>>> tb/sv/tb_servo_command_packet_framer.sv
// tb_servo_command_packet_framer: self-checking bench for the servo command packet framer
// drives commands, predicts every instruction packet byte and checks the byte stream
// depends on scpf_pkg and servo_command_packet_framer
module tb_servo_command_packet_framer;
    timeunit 1ns;
    timeprecision 1ps;

    import scpf_pkg::*;

    // mode codes the block takes but never frames
    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    scpf_cmd_t cmd = '0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    scpf_out_t pkt;
    logic      pkt_valid;
    logic      pkt_stall = 1'b0;

    // commands waiting to be driven and packet bytes waiting to be seen
    scpf_cmd_t   cmd_queue[$];
    scpf_out_t   packet_bytes_due[$];
    int unsigned cmds_queued = 0;
    int unsigned cmds_taken = 0;
    int unsigned mismatches = 0;
    int unsigned hold_asks = 0;
    bit          cmd_took = 1'b0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    servo_command_packet_framer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .pkt       (pkt),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // limit and position writes never send a word above the clamp
    function automatic logic [15:0] clamp_to_limit(input logic [15:0] w);
        return (w > CLAMP_MAX) ? CLAMP_MAX : w;
    endfunction

    // builds the instruction packet for one command and queues its bytes
    function automatic void frame_servo_command(input scpf_cmd_t c);
        logic [7:0]  frame[$];
        logic [7:0]  csum;
        logic [15:0] lim_a;
        logic [15:0] lim_b;
        scpf_out_t   ob;
        lim_a = clamp_to_limit(c.word_a);
        lim_b = clamp_to_limit(c.word_b);
        case (c.mode)
            MODE_PING:
                frame = {HEADER_BYTE, HEADER_BYTE, c.servo_id, LEN_SHORT, INSTR_PING};
            MODE_LIMIT:
                frame = {HEADER_BYTE, HEADER_BYTE, c.servo_id, LEN_WRITE, INSTR_WRITE,
                         ADDR_CW_LIMIT, lim_a[7:0], lim_a[15:8], lim_b[7:0], lim_b[15:8]};
            MODE_POSITION:
                frame = {HEADER_BYTE, HEADER_BYTE, c.servo_id, LEN_WRITE, INSTR_WRITE,
                         ADDR_GOAL_POS, lim_a[7:0], lim_a[15:8], lim_b[7:0], lim_b[15:8]};
            MODE_REGISTERED:
                frame = {HEADER_BYTE, HEADER_BYTE, c.servo_id, LEN_WRITE, INSTR_REG_WRITE,
                         ADDR_GOAL_POS, c.word_a[7:0], c.word_a[15:8],
                         c.word_b[7:0], c.word_b[15:8]};
            MODE_ACTION:
                frame = {HEADER_BYTE, HEADER_BYTE, BROADCAST_ID, LEN_SHORT, INSTR_ACTION};
            MODE_SYNC:
                frame = {HEADER_BYTE, HEADER_BYTE, BROADCAST_ID, LEN_SYNC, INSTR_SYNC,
                         ADDR_GOAL_POS, SYNC_DATA_LEN, c.servo_id,
                         c.word_a[7:0], c.word_a[15:8], c.word_b[7:0], c.word_b[15:8],
                         c.servo_id_two,
                         c.word_c[7:0], c.word_c[15:8], c.word_d[7:0], c.word_d[15:8]};
            default:
                return;
        endcase
        // checksum covers everything after the two header bytes
        csum = '0;
        foreach (frame[i])
        begin
            if (i >= 2)
                csum += frame[i];
        end
        frame.push_back(~csum);
        foreach (frame[i])
        begin
            ob.packet_byte = frame[i];
            ob.last_byte   = (i == frame.size() - 1);
            packet_bytes_due.push_back(ob);
        end
    endfunction

    // word values weighted toward the clamp boundary and the extremes
    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return CLAMP_MAX;
            3: return CLAMP_MAX + 16'd1;
            4: return CLAMP_MAX - 16'd1;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_id();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return BROADCAST_ID;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_command(input logic [2:0] mode, input logic [7:0] id,
                               input logic [15:0] wa, input logic [15:0] wb,
                               input logic [7:0] id2, input logic [15:0] wc,
                               input logic [15:0] wd);
        scpf_cmd_t c;
        c.mode         = mode;
        c.servo_id     = id;
        c.word_a       = wa;
        c.word_b       = wb;
        c.servo_id_two = id2;
        c.word_c       = wc;
        c.word_d       = wd;
        cmd_queue.push_back(c);
        cmds_queued++;
    endtask

    // mostly legal modes, now and then one of the undefined ones
    task automatic add_random_commands(input int count);
        int unsigned r;
        logic [2:0]  mode;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(19);
            if (r < 18)
                mode = 3'(r % (int'(MODE_SYNC) + 1));
            else
                mode = (r == 18) ? MODE_UNDEF_LO : MODE_UNDEF_HI;
            add_command(mode, pick_id(), pick_word(), pick_word(), pick_id(),
                        pick_word(), pick_word());
        end
    endtask

    task automatic wait_drained();
        while (cmds_taken != cmds_queued || packet_bytes_due.size() != 0)
            @(negedge clk);
    endtask

    // command driver: a new request only once the current one is taken
    always @(negedge clk)
    begin : cmd_driver
        logic      offer;
        scpf_cmd_t next_cmd;
        if (rst_n && (!cmd_valid || cmd_took))
        begin
            offer    = 1'b0;
            next_cmd = cmd;
            if (cmd_queue.size() != 0 && (tx_calm || $urandom_range(99) >= IDLE_PCT))
            begin
                offer    = 1'b1;
                next_cmd = cmd_queue.pop_front();
            end
            cmd_valid <= offer;
            cmd       <= next_cmd;
        end
    end

    // packet receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin : pkt_receiver
        int unsigned holds_served;
        int          hold_left;
        if (holds_served != hold_asks)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pkt_stall <= 1'b1;
        end
        else
        begin
            pkt_stall <= !rx_calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // accept commands into the predictor and check every packet byte
    always @(posedge clk)
    begin : pkt_monitor
        scpf_out_t want;
        cmd_took = rst_n && cmd_valid && !cmd_stall;
        if (cmd_took)
        begin
            cmds_taken++;
            frame_servo_command(cmd);
        end
        if (rst_n && pkt_valid && !pkt_stall)
        begin
            if (packet_bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected packet byte %02h last %0b", pkt.packet_byte,
                             pkt.last_byte);
            end
            else
            begin
                want = packet_bytes_due.pop_front();
                if (pkt.packet_byte !== want.packet_byte || pkt.last_byte !== want.last_byte)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("packet byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.packet_byte, want.last_byte, pkt.packet_byte,
                                 pkt.last_byte);
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every mode, field extremes, clamp boundary, ignored fields
        add_command(MODE_PING, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000);
        add_command(MODE_PING, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_command(MODE_LIMIT, 8'h01, 16'h0000, 16'hFFFF, 8'hAA, 16'h1234, 16'h5678);
        add_command(MODE_LIMIT, 8'h7F, CLAMP_MAX, CLAMP_MAX + 16'd1, 8'h00, 16'h0, 16'h0);
        add_command(MODE_LIMIT, 8'h80, CLAMP_MAX - 16'd1, 16'h8000, 8'h00, 16'h0, 16'h0);
        add_command(MODE_POSITION, 8'hFE, 16'hFFFF, 16'h0000, 8'h55, 16'hFFFF, 16'h0);
        add_command(MODE_POSITION, 8'h12, CLAMP_MAX + 16'd1, CLAMP_MAX, 8'h00, 16'h0, 16'h0);
        add_command(MODE_POSITION, 8'h00, 16'h03FE, 16'h0001, 8'h00, 16'h0, 16'h0);
        add_command(MODE_REGISTERED, 8'hFF, 16'hFFFF, 16'h0000, 8'h00, 16'h0, 16'h0);
        add_command(MODE_REGISTERED, 8'h00, 16'h0000, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_command(MODE_REGISTERED, 8'h3C, 16'h1234, 16'hABCD, 8'h00, 16'h0, 16'h0);
        add_command(MODE_ACTION, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0, 16'h0);
        add_command(MODE_ACTION, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_command(MODE_SYNC, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000);
        add_command(MODE_SYNC, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_command(MODE_SYNC, 8'h01, 16'h0400, 16'h8001, 8'hFE, 16'h7FFF, 16'h03FF);
        add_command(MODE_UNDEF_LO, 8'h11, 16'h1111, 16'h2222, 8'h33, 16'h4444, 16'h5555);
        add_command(MODE_PING, 8'h42, 16'h0, 16'h0, 8'h0, 16'h0, 16'h0);
        add_command(MODE_UNDEF_HI, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_command(MODE_SYNC, 8'hA5, 16'h5A5A, 16'hA5A5, 8'h5A, 16'hC3C3, 16'h3C3C);
        wait_drained();

        // receiver holds off while the sender keeps offering; the queue fills up
        tx_calm = 1'b1;
        hold_asks++;
        add_random_commands(10);
        wait_drained();
        tx_calm = 1'b0;

        // a stretch with no idling on either side
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        add_random_commands(40);
        wait_drained();
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // random bulk in chunks; the sender pauses between chunks until all bytes are out
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            add_random_commands(60);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && packet_bytes_due.size() == 0)
            $display("servo_command_packet_framer test passed");
        else
            $display("servo_command_packet_framer test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_400_000;
        $display("servo_command_packet_framer test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/scpf_pkg.sv
rtl/core/scpf_front.sv
rtl/core/scpf_queue.sv
rtl/core/scpf_back.sv
rtl/core/servo_command_packet_framer.sv
rtl/core/scpf_checker.sv
tb/sv/tb_servo_command_packet_framer.sv
